// ----- hw/rtl/fdsr_pkg.sv -----
// Shared types, constants and request codes of the fan duty slew ramp block.
`timescale 1ns / 1ps
`default_nettype none

package fdsr_pkg;

   // Speed level range; the top level is the divisor of the target scale.
   localparam int LEVEL_COUNT = 100;
   localparam int LEVEL_TOP   = LEVEL_COUNT - 1;
   localparam int LEVEL_RESET = (49 > LEVEL_TOP) ? LEVEL_TOP : 49;
   localparam int LEVEL_W     = 7;

   // Suction arrives in percent.
   localparam int PCT_FULL = 100;

   // Reciprocal scaling for division by a constant: q0 = (x * M) >> RECIP_SHIFT
   // is the true quotient or one below it for x under 2**15.
   localparam int RECIP_SHIFT = 16;
   localparam int RECIP_PCT   = (1 << RECIP_SHIFT) / PCT_FULL;
   localparam int RECIP_TOP   = (1 << RECIP_SHIFT) / LEVEL_TOP;

   // Shared multiplier operand and product widths.
   localparam int MUL_A_W = 16;
   localparam int MUL_B_W = 17;
   localparam int MUL_P_W = MUL_A_W + MUL_B_W;

   // Request codes carried on req_tuser.
   localparam logic [2:0] REQ_COOL   = 3'd0;
   localparam logic [2:0] REQ_TICK   = 3'd1;
   localparam logic [2:0] REQ_TOGGLE = 3'd2;
   localparam logic [2:0] REQ_CYCLE  = 3'd3;
   localparam logic [2:0] REQ_OFF    = 3'd4;

   // Configuration register indexes.
   localparam logic [1:0] CSR_MIN_DUTY  = 2'd0;
   localparam logic [1:0] CSR_MAX_DUTY  = 2'd1;
   localparam logic [1:0] CSR_RAMP_RATE = 2'd2;

   typedef struct packed {
      logic [7:0]  min_duty;
      logic [7:0]  max_duty;
      logic [15:0] ramp_rate;
   } cfg_type;

   typedef struct packed {
      logic [2:0]         kind;
      logic [9:0]         elapsed_time;
      logic               local_cooling;
      logic               belt_cooling;
      logic [6:0]         suction_level;
   } item_type;

   typedef struct packed {
      logic [7:0]         duty;
      logic               fan_on;
      logic [LEVEL_W-1:0] speed_level;
      logic [7:0]         goal_duty;
      logic               settled;
   } res_type;

   typedef struct packed {
      logic [MUL_A_W-1:0] a;
      logic [MUL_B_W-1:0] b;
   } mul_req_type;

endpackage

`default_nettype wire

// ----- hw/rtl/fdsr_mul.sv -----
// Shared unsigned multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none

module fdsr_mul (
   input  wire logic                         clock,
   input  wire fdsr_pkg::mul_req_type        mul_req,
   output logic [fdsr_pkg::MUL_P_W-1:0]      mul_prod
);

   logic [fdsr_pkg::MUL_P_W-1:0] prod_ff;
   logic [fdsr_pkg::MUL_P_W-1:0] prod_in;

   always_comb begin
      prod_in = fdsr_pkg::MUL_P_W'(mul_req.a) * fdsr_pkg::MUL_P_W'(mul_req.b);
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign mul_prod = prod_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/fdsr_seq.sv -----
// Sequencer and state of the fan duty ramp; drives the shared multiplier.
`timescale 1ns / 1ps
`default_nettype none

module fdsr_seq (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire fdsr_pkg::cfg_type            cfg,
   input  wire logic                         item_fire,
   input  wire fdsr_pkg::item_type           item,
   output logic                              item_ready,
   output logic                              res_valid,
   input  wire logic                         res_load,
   output fdsr_pkg::res_type                 res,
   output fdsr_pkg::mul_req_type             mul_req,
   input  wire logic [fdsr_pkg::MUL_P_W-1:0] mul_prod
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_PROD = 3'd1;
   localparam logic [2:0] ST_RCP  = 3'd2;
   localparam logic [2:0] ST_QUO  = 3'd3;
   localparam logic [2:0] ST_FIX  = 3'd4;
   localparam logic [2:0] ST_STEP = 3'd5;
   localparam logic [2:0] ST_DONE = 3'd6;

   localparam logic [1:0] PH_LEVEL  = 2'd0;
   localparam logic [1:0] PH_TARGET = 2'd1;
   localparam logic [1:0] PH_TICK   = 2'd2;

   localparam logic [15:0] HALF_DUTY = 16'd128;

   localparam int LW = fdsr_pkg::LEVEL_W;

   logic [2:0]    state_ff,   state_in;
   logic [1:0]    phase_ff,   phase_in;
   logic [LW-1:0] level_ff,   level_in;
   logic          enabled_ff, enabled_in;
   logic [15:0]   ramp_ff,    ramp_in;
   logic [7:0]    target_ff,  target_in;
   logic [15:0]   x_ff,       x_in;
   logic [15:0]   q_ff,       q_in;
   logic [9:0]    elapsed_ff, elapsed_in;
   logic [6:0]    suction_ff, suction_in;

   logic [6:0]    suction_cl;
   logic [7:0]    level_inc;
   logic [7:0]    span;
   logic [LW-1:0] level_cap;
   logic [15:0]   divisor;
   logic [15:0]   remainder;
   logic [15:0]   quotient;
   logic [9:0]    target_sum;
   logic [15:0]   goal;
   logic [15:0]   err;
   logic [15:0]   step;
   logic [16:0]   round_sum;

   always_comb begin
      suction_cl = (item.suction_level > 7'(fdsr_pkg::PCT_FULL))
                   ? 7'(fdsr_pkg::PCT_FULL) : item.suction_level;
      level_inc  = {1'b0, level_ff} + 8'd1;
      span       = (cfg.max_duty >= cfg.min_duty) ? (cfg.max_duty - cfg.min_duty) : 8'd0;
      level_cap  = (level_ff > LW'(fdsr_pkg::LEVEL_TOP)) ? LW'(fdsr_pkg::LEVEL_TOP) : level_ff;
      divisor    = (phase_ff == PH_LEVEL) ? 16'(fdsr_pkg::PCT_FULL)
                                          : 16'(fdsr_pkg::LEVEL_TOP);
      remainder  = x_ff - mul_prod[15:0];
      quotient   = q_ff + ((remainder >= divisor) ? 16'd1 : 16'd0);
      target_sum = 10'(cfg.min_duty) + 10'(quotient[8:0]);
      goal       = {target_ff, 8'h00};
      err        = (goal >= ramp_ff) ? (goal - ramp_ff) : (ramp_ff - goal);
      step       = (|mul_prod[fdsr_pkg::MUL_P_W-1:16]) ? 16'hFFFF : mul_prod[15:0];
      round_sum  = 17'(ramp_ff) + 17'(HALF_DUTY);
   end

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      level_in   = level_ff;
      enabled_in = enabled_ff;
      ramp_in    = ramp_ff;
      target_in  = target_ff;
      x_in       = x_ff;
      q_in       = q_ff;
      elapsed_in = elapsed_ff;
      suction_in = suction_ff;
      mul_req.a  = '0;
      mul_req.b  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (item_fire) begin
               elapsed_in = item.elapsed_time;
               suction_in = suction_cl;
               state_in   = ST_DONE;
               case (item.kind)
                  fdsr_pkg::REQ_COOL: begin
                     if ((item.local_cooling || item.belt_cooling) && suction_cl != 7'd0) begin
                        enabled_in = 1'b1;
                        phase_in   = PH_LEVEL;
                        state_in   = ST_PROD;
                     end else begin
                        enabled_in = 1'b0;
                        target_in  = 8'd0;
                     end
                  end
                  fdsr_pkg::REQ_TICK: begin
                     if (item.elapsed_time != 10'd0) begin
                        phase_in = PH_TICK;
                        state_in = ST_PROD;
                     end
                  end
                  fdsr_pkg::REQ_TOGGLE: begin
                     enabled_in = ~enabled_ff;
                     if (!enabled_ff) begin
                        phase_in = PH_TARGET;
                        state_in = ST_PROD;
                     end else begin
                        target_in = 8'd0;
                     end
                  end
                  fdsr_pkg::REQ_CYCLE: begin
                     level_in   = (level_inc >= 8'(fdsr_pkg::LEVEL_COUNT))
                                  ? '0 : level_inc[LW-1:0];
                     enabled_in = 1'b1;
                     phase_in   = PH_TARGET;
                     state_in   = ST_PROD;
                  end
                  fdsr_pkg::REQ_OFF: begin
                     enabled_in = 1'b0;
                     target_in  = 8'd0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_PROD: begin
            // issue the first product of the phase
            case (phase_ff)
               PH_LEVEL: begin
                  mul_req.a = 16'(suction_ff);
                  mul_req.b = 17'(fdsr_pkg::LEVEL_TOP);
               end
               PH_TARGET: begin
                  mul_req.a = 16'(span);
                  mul_req.b = 17'(level_cap);
               end
               default: begin
                  mul_req.a = cfg.ramp_rate;
                  mul_req.b = 17'(elapsed_ff);
               end
            endcase
            state_in = (phase_ff == PH_TICK) ? ST_STEP : ST_RCP;
         end
         ST_RCP: begin
            // hold the dividend, scale it by the reciprocal
            x_in      = mul_prod[15:0];
            mul_req.a = mul_prod[15:0];
            mul_req.b = (phase_ff == PH_LEVEL) ? 17'(fdsr_pkg::RECIP_PCT)
                                               : 17'(fdsr_pkg::RECIP_TOP);
            state_in  = ST_QUO;
         end
         ST_QUO: begin
            // estimated quotient, then multiply back for the remainder
            q_in      = mul_prod[fdsr_pkg::RECIP_SHIFT +: 16];
            mul_req.a = mul_prod[fdsr_pkg::RECIP_SHIFT +: 16];
            mul_req.b = 17'(divisor);
            state_in  = ST_FIX;
         end
         ST_FIX: begin
            if (phase_ff == PH_LEVEL) begin
               level_in = quotient[LW-1:0];
               phase_in = PH_TARGET;
               state_in = ST_PROD;
            end else begin
               target_in = (target_sum > 10'd255) ? 8'd255 : target_sum[7:0];
               state_in  = ST_DONE;
            end
         end
         ST_STEP: begin
            if (err < HALF_DUTY || err <= step) begin
               ramp_in = goal;
            end else if (goal > ramp_ff) begin
               ramp_in = ramp_ff + step;
            end else begin
               ramp_in = ramp_ff - step;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (res_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         phase_ff   <= PH_LEVEL;
         level_ff   <= LW'(fdsr_pkg::LEVEL_RESET);
         enabled_ff <= 1'b0;
         ramp_ff    <= 16'd0;
         target_ff  <= 8'd0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         level_ff   <= level_in;
         enabled_ff <= enabled_in;
         ramp_ff    <= ramp_in;
         target_ff  <= target_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      q_ff       <= q_in;
      elapsed_ff <= elapsed_in;
      suction_ff <= suction_in;
   end

   assign item_ready      = (state_ff == ST_IDLE);
   assign res_valid       = (state_ff == ST_DONE);
   assign res.duty        = round_sum[16] ? 8'hFF : round_sum[15:8];
   assign res.fan_on      = enabled_ff;
   assign res.speed_level = level_ff;
   assign res.goal_duty   = target_ff;
   assign res.settled     = (ramp_ff == goal);

endmodule

`default_nettype wire

// ----- hw/rtl/fan_duty_slew_ramp.sv -----
// Top level of the fan PWM duty controller with slew-rate limited ramp.
`timescale 1ns / 1ps
`default_nettype none

// Fan duty controller. Each request transfer on req_ (kind on req_tuser) updates the
// speed level and on flag, recomputes the target duty, or on a ramp tick moves the
// 8.8 ramp value toward the target by at most ramp_rate * elapsed_time, or straight onto
// it when within half a duty unit; each request yields exactly one response transfer on
// rsp_ with the state after it. All multiplications and divisions run through one shared
// registered multiplier under a sequencer, so req_tready is low from the accepting edge
// until the result moves into the output register. Force off, a cooling update that turns
// the fan off, toggling off, an unknown kind and a tick with zero elapsed time go straight
// to the result; a ramp tick makes one product and then the step; toggling on and cycling
// the level make one division by a constant; a cooling update that turns the fan on makes
// two (each division three passes through the multiplier). The request side is ready again
// once the result moves into the output register, so a result waiting there does not hold
// off the next request, only the one after it once that next one finishes.
// Configuration writes take effect at the next event and do not recompute the target.

module fan_duty_slew_ramp (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [9:0] elapsed_time, [10] local_cooling, [11] belt_cooling, [18:12] suction_level
   input  wire logic [23:0] req_tdata,
   // [2:0] req_type
   input  wire logic [2:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [7:0] duty, [8] fan_on, [15:9] speed_level, [23:16] goal_duty, [24] settled
   output logic [31:0]      rsp_tdata,
   input  wire logic        csr_wr_en,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_wdata
);

   fdsr_pkg::cfg_type     cfg_ff, cfg_in;
   fdsr_pkg::item_type    item;
   fdsr_pkg::res_type     res;
   fdsr_pkg::res_type     rsp_ff, rsp_in;
   fdsr_pkg::mul_req_type mul_req;
   logic [fdsr_pkg::MUL_P_W-1:0] mul_prod;

   logic rsp_valid_ff, rsp_valid_in;
   logic item_ready;
   logic item_fire;
   logic res_valid;
   logic res_load;

   // Unpack the request transfer.
   assign item.kind          = req_tuser;
   assign item.elapsed_time  = req_tdata[9:0];
   assign item.local_cooling = req_tdata[10];
   assign item.belt_cooling  = req_tdata[11];
   assign item.suction_level = req_tdata[18:12];

   assign req_tready = item_ready;
   assign item_fire  = req_tvalid && item_ready;

   // Configuration writes; an index past the list is dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            fdsr_pkg::CSR_MIN_DUTY:  cfg_in.min_duty  = csr_wdata[7:0];
            fdsr_pkg::CSR_MAX_DUTY:  cfg_in.max_duty  = csr_wdata[7:0];
            fdsr_pkg::CSR_RAMP_RATE: cfg_in.ramp_rate = csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Load the output register when it is empty or its transfer completes.
   assign res_load = res_valid && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      if (res_load) begin
         rsp_in       = res;
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_duty  <= 8'd0;
         cfg_ff.max_duty  <= 8'd255;
         cfg_ff.ramp_rate <= 16'd256;
         rsp_valid_ff     <= 1'b0;
      end else begin
         cfg_ff           <= cfg_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   fdsr_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .item_fire  (item_fire),
      .item       (item),
      .item_ready (item_ready),
      .res_valid  (res_valid),
      .res_load   (res_load),
      .res        (res),
      .mul_req    (mul_req),
      .mul_prod   (mul_prod)
   );

   fdsr_mul u_mul (
      .clock    (clock),
      .mul_req  (mul_req),
      .mul_prod (mul_prod)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_ff.settled, rsp_ff.goal_duty, rsp_ff.speed_level,
                        rsp_ff.fan_on, rsp_ff.duty};

endmodule

`default_nettype wire

// ----- hw/rtl/fdsr_checker.sv -----
// Port-level checks of the fan duty ramp block and their bind to the top level.
`timescale 1ns / 1ps
`default_nettype none

module fdsr_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [31:0] rsp_tdata
);

   // A stalled response holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // The request side is not ready in the cycle after an accepted request.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request side ready right after a transfer");

   // With the fan off the goal duty is zero.
   a_off_goal_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[8] |-> rsp_tdata[23:16] == 8'd0)
      else $error("fan off with nonzero goal duty");

   // A settled ramp reports the goal as its duty, and the level stays in range.
   a_settled_duty: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[24] |-> rsp_tdata[7:0] == rsp_tdata[23:16])
      else $error("settled ramp with duty off goal");

   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> {1'b0, rsp_tdata[15:9]} < 8'(fdsr_pkg::LEVEL_COUNT))
      else $error("speed level out of range");

endmodule

bind fan_duty_slew_ramp fdsr_checker u_fdsr_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ----- dv/tb_fan_duty_slew_ramp.sv -----
// Self-checking testbench for the fan duty slew ramp controller.
`timescale 1ns / 1ps

module tb_fan_duty_slew_ramp;

   // Request kinds the block must ignore, and the register index past the list.
   localparam logic [2:0] REQ_SPARE_LO  = 3'd5;
   localparam logic [2:0] REQ_SPARE_MID = 3'd6;
   localparam logic [2:0] REQ_SPARE_HI  = 3'd7;
   localparam logic [1:0] CSR_SPARE     = 2'd3;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [23:0] req_tdata;
   logic [2:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   // Fan controller mirror: level, on flag, 8.8 ramp value and goal duty.
   int unsigned lvl_now;
   int unsigned fan_en;
   int unsigned ramp_q88;
   int unsigned goal_now;
   int unsigned cfg_min;
   int unsigned cfg_max;
   int unsigned cfg_rate;

   // Status words predicted per accepted request, oldest first.
   fdsr_pkg::res_type status_due[$];

   int fail_count = 0;
   int rx_hold    = 0;   // receiver hold-off, in cycles, requested by a test
   bit tx_free    = 0;   // sender offers back-to-back while set

   always #4 clock = ~clock;

   fan_duty_slew_ramp dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // ---------------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------------

   function automatic void clear_fan_state();
      cfg_min  = 0;
      cfg_max  = 255;
      cfg_rate = 256;
      lvl_now  = fdsr_pkg::LEVEL_RESET;
      fan_en   = 0;
      ramp_q88 = 0;
      goal_now = 0;
   endfunction

   // Goal duty: min + span * level / top, zero when off; an inverted range has no span.
   function automatic void refresh_goal();
      int unsigned span;
      int unsigned t;
      if (fan_en == 0) begin
         goal_now = 0;
         return;
      end
      span = (cfg_max >= cfg_min) ? cfg_max - cfg_min : 0;
      t = cfg_min + span * lvl_now / fdsr_pkg::LEVEL_TOP;
      goal_now = (t > 255) ? 255 : t;
   endfunction

   // Move the ramp toward the goal; snap when within half a unit or within one step.
   function automatic void ramp_toward_goal(int unsigned elapsed);
      int unsigned target;
      int unsigned err;
      int unsigned step;
      if (elapsed == 0)
         return;
      target = goal_now << 8;
      err = (target >= ramp_q88) ? target - ramp_q88 : ramp_q88 - target;
      if (err < 128) begin
         ramp_q88 = target;
         return;
      end
      step = cfg_rate * elapsed;
      if (step > 65535)
         step = 65535;
      if (err <= step)
         ramp_q88 = target;
      else if (target > ramp_q88)
         ramp_q88 = ramp_q88 + step;
      else
         ramp_q88 = ramp_q88 - step;
   endfunction

   // Apply one request to the mirror and return the status the block must report.
   function automatic fdsr_pkg::res_type apply_fan_event(fdsr_pkg::item_type it);
      fdsr_pkg::res_type st;
      int unsigned       suct;
      int unsigned       rounded;
      suct = (it.suction_level > fdsr_pkg::PCT_FULL) ? fdsr_pkg::PCT_FULL
                                                     : it.suction_level;
      case (it.kind)
         fdsr_pkg::REQ_COOL: begin
            if ((it.local_cooling || it.belt_cooling) && suct > 0) begin
               lvl_now = suct * fdsr_pkg::LEVEL_TOP / fdsr_pkg::PCT_FULL;
               fan_en  = 1;
            end else begin
               fan_en = 0;
            end
            refresh_goal();
         end
         fdsr_pkg::REQ_TICK: begin
            ramp_toward_goal(it.elapsed_time);
         end
         fdsr_pkg::REQ_TOGGLE: begin
            fan_en = fan_en ^ 1;
            refresh_goal();
         end
         fdsr_pkg::REQ_CYCLE: begin
            lvl_now = (lvl_now + 1 >= fdsr_pkg::LEVEL_COUNT) ? 0 : lvl_now + 1;
            fan_en  = 1;
            refresh_goal();
         end
         fdsr_pkg::REQ_OFF: begin
            fan_en = 0;
            refresh_goal();
         end
         default: ;
      endcase
      rounded = (ramp_q88 + 128) >> 8;
      if (rounded > 255)
         rounded = 255;
      st.duty        = rounded[7:0];
      st.fan_on      = fan_en[0];
      st.speed_level = lvl_now[fdsr_pkg::LEVEL_W-1:0];
      st.goal_duty   = goal_now[7:0];
      st.settled     = (ramp_q88 == (goal_now << 8));
      return st;
   endfunction

   // ---------------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------------

   function automatic fdsr_pkg::item_type make_item(logic [2:0] kind, int unsigned elapsed,
                                                    bit loc, bit belt, int unsigned suct);
      fdsr_pkg::item_type it;
      it.kind          = kind;
      it.elapsed_time  = elapsed[9:0];
      it.local_cooling = loc;
      it.belt_cooling  = belt;
      it.suction_level = suct[6:0];
      return it;
   endfunction

   // Mostly cooling updates and ticks, so the ramp gets to chase moving goals.
   function automatic fdsr_pkg::item_type random_item();
      fdsr_pkg::item_type it;
      int unsigned        r;
      r = $urandom_range(0, 99);
      if (r < 25)      it.kind = fdsr_pkg::REQ_COOL;
      else if (r < 60) it.kind = fdsr_pkg::REQ_TICK;
      else if (r < 72) it.kind = fdsr_pkg::REQ_TOGGLE;
      else if (r < 86) it.kind = fdsr_pkg::REQ_CYCLE;
      else if (r < 94) it.kind = fdsr_pkg::REQ_OFF;
      else             it.kind = 3'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
      r = $urandom_range(0, 99);
      if (r < 70)      it.elapsed_time = 10'($urandom_range(1, 24));
      else if (r < 88) it.elapsed_time = 10'($urandom_range(0, 1023));
      else             it.elapsed_time = 10'($urandom_range(0, 3));
      r = $urandom_range(0, 99);
      if (r < 80)
         it.suction_level = 7'($urandom_range(0, fdsr_pkg::PCT_FULL));
      else if (r < 90)
         it.suction_level = ($urandom_range(0, 1) != 0) ? 7'(fdsr_pkg::PCT_FULL) : 7'd0;
      else
         it.suction_level = 7'($urandom_range(fdsr_pkg::PCT_FULL + 1, 127));
      it.local_cooling = 1'($urandom_range(0, 1));
      it.belt_cooling  = 1'($urandom_range(0, 1));
      return it;
   endfunction

   // Sender idle gap after a transfer: mostly none or short, now and then long.
   function automatic int pick_gap();
      int unsigned r;
      if (tx_free)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Offer one request, hold it until the transfer, then predict its status.
   task automatic send_item(fdsr_pkg::item_type it);
      int gap;
      gap = pick_gap();
      req_tvalid <= 1'b1;
      req_tuser  <= it.kind;
      req_tdata  <= {5'd0, it.suction_level, it.belt_cooling, it.local_cooling,
                     it.elapsed_time};
      do
         @(posedge clock);
      while (!req_tready);
      status_due.push_back(apply_fan_event(it));
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Drop valid and wait until every predicted status has come back.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (status_due.size() != 0)
         @(posedge clock);
      // allow for the longest request latency before touching registers
      repeat (10) @(posedge clock);
   endtask

   // Write one register with a one-cycle enable strobe.
   task automatic write_reg(logic [1:0] idx, int unsigned val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[15:0];
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         fdsr_pkg::CSR_MIN_DUTY:  cfg_min  = val & 8'hFF;
         fdsr_pkg::CSR_MAX_DUTY:  cfg_max  = val & 8'hFF;
         fdsr_pkg::CSR_RAMP_RATE: cfg_rate = val & 16'hFFFF;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // Call only while the block is idle.
   task automatic set_config(int unsigned lo, int unsigned hi, int unsigned rate);
      write_reg(fdsr_pkg::CSR_MIN_DUTY, lo);
      write_reg(fdsr_pkg::CSR_MAX_DUTY, hi);
      write_reg(fdsr_pkg::CSR_RAMP_RATE, rate);
   endtask

   // ---------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------

   // Report the state right out of reset: level 49, fan off, ramp at zero.
   task automatic test_reset_state();
      send_item(make_item(REQ_SPARE_LO, 0, 0, 0, 0));
      send_item(make_item(fdsr_pkg::REQ_TICK, 0, 1, 1, 100));
      send_item(make_item(REQ_SPARE_MID, 1023, 1, 1, 127));
   endtask

   // Walk every request kind and the corner cases of each.
   task automatic test_events();
      send_item(make_item(fdsr_pkg::REQ_COOL, 0, 1, 0, 100));     // full suction, top level
      send_item(make_item(fdsr_pkg::REQ_TICK, 1023, 0, 0, 0));    // saturated step, snap
      send_item(make_item(fdsr_pkg::REQ_CYCLE, 0, 0, 0, 0));      // wrap to level 0
      send_item(make_item(fdsr_pkg::REQ_COOL, 0, 0, 1, 127));     // suction above range
      send_item(make_item(fdsr_pkg::REQ_COOL, 0, 0, 0, 50));      // no cooling need: off
      send_item(make_item(fdsr_pkg::REQ_COOL, 0, 1, 1, 0));       // zero suction: off
      send_item(make_item(fdsr_pkg::REQ_TOGGLE, 0, 0, 0, 0));     // on at the kept level
      send_item(make_item(fdsr_pkg::REQ_TICK, 1, 0, 0, 0));       // step of one duty unit
      send_item(make_item(fdsr_pkg::REQ_TOGGLE, 0, 0, 0, 0));     // off
      send_item(make_item(fdsr_pkg::REQ_CYCLE, 0, 0, 0, 0));      // cycling turns on
      send_item(make_item(fdsr_pkg::REQ_COOL, 0, 1, 0, 1));       // lowest nonzero suction
      send_item(make_item(fdsr_pkg::REQ_COOL, 0, 1, 0, 51));
      send_item(make_item(fdsr_pkg::REQ_OFF, 0, 1, 1, 100));
      send_item(make_item(REQ_SPARE_HI, 0, 0, 0, 0));
      send_item(make_item(fdsr_pkg::REQ_TICK, 1023, 1, 1, 127));  // ramp back down
      wait_drained();
   endtask

   // Inverted range, zero rate, full rate and a write past the register list.
   task automatic test_register_extremes();
      write_reg(CSR_SPARE, 16'hFFFF);
      set_config(200, 100, 0);
      send_item(make_item(fdsr_pkg::REQ_CYCLE, 0, 0, 0, 0));      // goal is min at any level
      send_item(make_item(fdsr_pkg::REQ_TICK, 1023, 0, 0, 0));    // zero rate: stays put
      wait_drained();
      set_config(255, 255, 65535);
      send_item(make_item(fdsr_pkg::REQ_CYCLE, 0, 0, 0, 0));
      send_item(make_item(fdsr_pkg::REQ_TICK, 1, 0, 0, 0));       // one tick covers it all
      send_item(make_item(fdsr_pkg::REQ_OFF, 0, 0, 0, 0));
      wait_drained();
   endtask

   // Random requests across several register settings, extremes included.
   task automatic test_random();
      for (int ph = 0; ph < 7; ph++) begin
         case (ph)
            0: set_config(0, 255, 256);
            1: set_config(0, 255, 65535);
            2: set_config(255, 0, 0);
            3: set_config($urandom_range(0, 255), $urandom_range(0, 255),
                          $urandom_range(1, 1024));
            4: set_config(0, 0, 1);
            5: set_config(255, 255, $urandom_range(0, 65535));
            default: set_config($urandom_range(0, 100), $urandom_range(150, 255),
                                $urandom_range(1, 64));
         endcase
         for (int n = 0; n < 107; n++) begin
            // switch between gapped traffic and back-to-back stretches
            if (n % 30 == 0)
               tx_free = ($urandom_range(0, 3) == 0);
            send_item(random_item());
         end
         tx_free = 0;
         wait_drained();
      end
   endtask

   // Hold the receiver off long enough to fill the block while requests keep coming.
   task automatic test_backpressure();
      rx_hold = 400;
      tx_free = 1;
      repeat (30) send_item(random_item());
      tx_free = 0;
      wait_drained();
   endtask

   // ---------------------------------------------------------------------------------
   // Response side: random ready, optional long hold-off
   // ---------------------------------------------------------------------------------

   initial begin
      int  seg;
      int  r;
      bit  stall;
      seg   = 0;
      stall = 0;
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rx_hold > 0) begin
            rsp_tready <= 1'b0;
            rx_hold = rx_hold - 1;
         end else begin
            if (seg == 0) begin
               r = $urandom_range(0, 99);
               if (r < 50) begin
                  stall = 0;
                  seg   = $urandom_range(1, 8);
               end else if (r < 60) begin
                  stall = 0;                          // long stretch with no stall
                  seg   = $urandom_range(30, 120);
               end else if (r < 90) begin
                  stall = 1;
                  seg   = $urandom_range(1, 3);
               end else begin
                  stall = 1;
                  seg   = $urandom_range(10, 50);
               end
            end
            rsp_tready <= !stall;
            seg = seg - 1;
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Response checking
   // ---------------------------------------------------------------------------------

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      fdsr_pkg::res_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (status_due.size() == 0) begin
            $error("response transfer with nothing expected: tdata %h", rsp_tdata);
            fail_count++;
         end else begin
            want = status_due.pop_front();
            check_field("duty",        want.duty,        rsp_tdata[7:0]);
            check_field("fan_on",      want.fan_on,      rsp_tdata[8]);
            check_field("speed_level", want.speed_level, rsp_tdata[15:9]);
            check_field("goal_duty",   want.goal_duty,   rsp_tdata[23:16]);
            check_field("settled",     want.settled,     rsp_tdata[24]);
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------------

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      csr_wr_en  <= 1'b0;
      csr_index  <= '0;
      csr_wdata  <= '0;
      clear_fan_state();
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      test_reset_state();
      test_events();
      test_register_extremes();
      test_random();
      test_backpressure();

      // let any stray response show up before the verdict
      repeat (40) @(posedge clock);
      if (status_due.size() != 0) begin
         $error("%0d responses never arrived", status_due.size());
         fail_count++;
      end
      if (fail_count == 0)
         $display("** fan_duty_slew_ramp: PASSED **");
      else
         $display("** fan_duty_slew_ramp: FAILED **");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run.
   initial begin
      #5_000_000;
      $display("** fan_duty_slew_ramp: FAILED **");
      $finish;
   end

endmodule
